[rtl/bus_answer_frame_checker_core_defines.svh]
// assertion macros used by the checker file of the answer frame checker
// depends on nothing; expects aclk and aresetn in the scope of each use
`ifndef BUS_ANSWER_FRAME_CHECKER_CORE_DEFINES_SVH
`define BUS_ANSWER_FRAME_CHECKER_CORE_DEFINES_SVH

// condition implies property in the same cycle
`define BAFC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle
`define BAFC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/bafc_pkg.sv]
// types and constants of the bus answer frame checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bafc_pkg;

    localparam int CMD_W     = 8;
    localparam int ADDR_W    = 6;
    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;
    localparam int NIBBLE_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ASYNC_BIT = 6;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_MASK   = 8'hF8;
    localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_ARM  = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMMAND = 2'd0,
        REG_ADDRESS = 2'd1,
        REG_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_PENDING    = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_NOT_ANSWER = 3'd2,
        ST_WRONG_CMD  = 3'd3,
        ST_WRONG_ADDR = 3'd4,
        ST_DEV_ERROR  = 3'd5,
        ST_TOO_LONG   = 3'd6,
        ST_TIMEOUT    = 3'd7
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0]    byte_index;
        logic [BYTE_W-1:0]   answer_byte;
        logic                byte_stored;
        logic [NIBBLE_W-1:0] device_error;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

[rtl/bafc_check.sv]
// frame check: config registers, wait/frame state and the per-word decision
// depends on bafc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bafc_check #(
    parameter int MAX_LEN = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bafc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [bafc_pkg::TICK_W-1:0]     cfg_wdata,
    input  wire logic                            in_acc,
    input  wire logic [1:0]                      in_op,
    input  wire logic [bafc_pkg::BYTE_W-1:0]     in_byte,
    output bafc_pkg::result_t                    res
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

    logic [bafc_pkg::CMD_W-1:0]  command_reg;
    logic [bafc_pkg::ADDR_W-1:0] address_reg;
    logic [bafc_pkg::TICK_W-1:0] timeout_reg;

    logic                        waiting_reg,  waiting_next;
    logic                        in_frame_reg, in_frame_next;
    logic [POS_W-1:0]            pos_reg,      pos_next;
    logic [bafc_pkg::TICK_W-1:0] elapsed_reg,  elapsed_next;
    logic [bafc_pkg::TICK_W-1:0] elapsed_inc;
    bafc_pkg::status_t           err;
    bafc_pkg::op_t               op;

    assign op = bafc_pkg::op_t'(in_op);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg <= '0;
            address_reg <= '0;
            timeout_reg <= bafc_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (bafc_pkg::cfg_reg_t'(cfg_addr))
                bafc_pkg::REG_COMMAND: command_reg <= cfg_wdata[bafc_pkg::CMD_W-1:0];
                bafc_pkg::REG_ADDRESS: address_reg <= cfg_wdata[bafc_pkg::ADDR_W-1:0];
                bafc_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg  <= 1'b0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            elapsed_reg  <= '0;
        end else if (in_acc) begin
            waiting_reg  <= waiting_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign elapsed_inc = (elapsed_reg == bafc_pkg::TICK_MAX) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;

    // header checks on body bytes 0 and 1
    always_comb begin
        err = bafc_pkg::ST_PENDING;
        if (pos_reg == '0) begin
            if (in_byte[0])
                err = bafc_pkg::ST_NOT_ANSWER;
            else if (!command_reg[bafc_pkg::ASYNC_BIT] &&
                     ((command_reg & bafc_pkg::CMD_MASK) != (in_byte & bafc_pkg::CMD_MASK)))
                err = bafc_pkg::ST_WRONG_CMD;
        end else if (pos_reg == POS_W'(1)) begin
            if (in_byte[bafc_pkg::ADDR_W-1:0] != address_reg)
                err = bafc_pkg::ST_WRONG_ADDR;
        end
    end

    always_comb begin
        waiting_next  = waiting_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        elapsed_next  = elapsed_reg;
        res           = '0;
        res.status    = bafc_pkg::ST_PENDING;
        case (op)
            bafc_pkg::OP_ARM: begin
                waiting_next  = 1'b1;
                in_frame_next = 1'b0;
                pos_next      = '0;
                elapsed_next  = '0;
            end
            bafc_pkg::OP_TICK: begin
                if (waiting_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= timeout_reg) begin
                        res.status    = bafc_pkg::ST_TIMEOUT;
                        waiting_next  = 1'b0;
                        in_frame_next = 1'b0;
                        pos_next      = '0;
                    end
                end
            end
            bafc_pkg::OP_BYTE: begin
                if (waiting_reg) begin
                    if (!in_frame_reg) begin
                        if (in_byte == bafc_pkg::START_BYTE) begin
                            in_frame_next = 1'b1;
                            pos_next      = '0;
                        end
                    end else if (pos_reg < POS_LIMIT) begin
                        if (err != bafc_pkg::ST_PENDING) begin
                            res.status    = err;
                            waiting_next  = 1'b0;
                            in_frame_next = 1'b0;
                            pos_next      = '0;
                        end else begin
                            res.byte_stored = 1'b1;
                            res.answer_byte = in_byte;
                            res.byte_index  = bafc_pkg::IDX_W'(pos_reg);
                            pos_next        = pos_reg + 1'b1;
                            // end marker counts only from body byte 2 on
                            if (pos_reg >= POS_W'(2) && in_byte[bafc_pkg::BYTE_W-1]) begin
                                if (in_byte[bafc_pkg::NIBBLE_W-1:0] != '0) begin
                                    res.status       = bafc_pkg::ST_DEV_ERROR;
                                    res.device_error = in_byte[bafc_pkg::NIBBLE_W-1:0];
                                end else begin
                                    res.status = bafc_pkg::ST_COMPLETE;
                                end
                                waiting_next  = 1'b0;
                                in_frame_next = 1'b0;
                            end
                        end
                    end else begin
                        res.status    = bafc_pkg::ST_TOO_LONG;
                        waiting_next  = 1'b0;
                        in_frame_next = 1'b0;
                        pos_next      = '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/bafc_skid.sv]
// result register with a skid stage so the input keeps flowing under stall until both hold a word
// depends on bafc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bafc_skid (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bafc_pkg::result_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bafc_pkg::result_t out_data
);

    logic              out_valid_reg,  out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bafc_pkg::result_t out_data_reg,   out_data_next;
    bafc_pkg::result_t skid_data_reg,  skid_data_next;
    logic              in_acc;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            // output slot frees up: skid word goes first
            out_valid_next  = skid_valid_reg || in_acc;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (in_acc) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[rtl/bus_answer_frame_checker_core.sv]
// Bus answer frame checker, top level.
// Input stream: one word per item; s_tuser is the operation (received byte,
// arm, tick) and s_tdata the received byte. Every accepted word yields exactly
// one result word on the m_ side: status, device error nibble, and, when the
// byte became part of the answer body, the byte and its index (m_tuser set).
// Arm starts a wait, bytes before the 0xFF start byte are dropped, header
// bytes are checked against the command and address registers, and ticks
// count toward the timeout register.
// The result of an accepted word is registered in the result register, or in the
// skid stage while the receiver stalls. Throughput: one word per cycle while
// s_tready is high; the decision is a single compare stage on the current byte and the frame position register.
// Stall: a result register plus a skid stage; s_tready drops only once both
// hold a word the receiver has not taken.
// Reset (aresetn low, synchronous): no wait active, position and tick count
// cleared, registers back to command 0, address 0, timeout 1000 ticks.
// User rule, not enforced by the block: write configuration through cfg_wr_en/cfg_addr/cfg_wdata only while idle.
`timescale 1ns / 1ps
`default_nettype none

module bus_answer_frame_checker_core #(
    parameter int MAX_LEN = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status[2:0], device_error[6:3],
                                        // answer_byte[14:7], byte_index[20:15], zero
    output logic             m_tuser    // byte_stored
);

    bafc_pkg::result_t chk_res;
    bafc_pkg::result_t out_res;
    logic              in_acc;

    assign in_acc = s_tvalid && s_tready;

    bafc_check #(
        .MAX_LEN (MAX_LEN)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_acc    (in_acc),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .res       (chk_res)
    );

    bafc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (chk_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {3'b000, out_res.byte_index, out_res.answer_byte,
                      out_res.device_error, out_res.status};
    assign m_tuser = out_res.byte_stored;

endmodule

`default_nettype wire

[rtl/bafc_checker.sv]
// port-level checks of the answer frame checker, bound to the top level
// depends on bafc_pkg and bus_answer_frame_checker_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "bus_answer_frame_checker_core_defines.svh"

module bafc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    `BAFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    `BAFC_ASSERT_NOW(a_unstored_zero, m_tvalid && !m_tuser, m_tdata[20:7] == 14'd0, "byte fields set on a word that was not stored")

    `BAFC_ASSERT_NOW(a_dev_err_only, m_tvalid && m_tdata[2:0] != bafc_pkg::ST_DEV_ERROR, m_tdata[6:3] == 4'd0, "device error nibble outside device error status")

    `BAFC_ASSERT_NOW(a_end_stored, m_tvalid && (m_tdata[2:0] == bafc_pkg::ST_COMPLETE || m_tdata[2:0] == bafc_pkg::ST_DEV_ERROR), m_tuser && m_tdata[20:15] >= 6'd2 && m_tdata[14], "frame end without a stored end byte")

endmodule

bind bus_answer_frame_checker_core bafc_checker u_bafc_checker (.*);

`default_nettype wire

[tb/sv/tb_bus_answer_frame_checker_core.sv]
// self-checking testbench for bus_answer_frame_checker_core: queued stimulus words,
// a per-word predictor of the reply check and an in-order result scoreboard
// depends on bafc_pkg and the core rtl
`timescale 1ns / 1ps

module tb_bus_answer_frame_checker_core;

    localparam int FRAME_MAX = 32;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx;
    } bus_word_t;

    typedef struct packed {
        bafc_pkg::status_t status;
        logic [3:0] nibble;
        logic       stored;
        logic [7:0] body_byte;
        logic [5:0] body_idx;
    } reply_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_NOT_ANSWER,
        FRAME_BAD_CMD,
        FRAME_BAD_ADDR,
        FRAME_OVERLONG,
        FRAME_SLOW
    } frame_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    bus_answer_frame_checker_core #(
        .MAX_LEN(FRAME_MAX)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // predictor copy of the registers and of the reply wait state
    logic [7:0]  cfg_command = '0;
    logic [5:0]  cfg_address = '0;
    logic [15:0] cfg_timeout = bafc_pkg::TIMEOUT_RESET;
    logic        rx_waiting = 1'b0;
    logic        rx_in_frame = 1'b0;
    logic [6:0]  rx_position = '0;
    logic [15:0] rx_elapsed = '0;

    bus_word_t word_q[$];
    reply_t    reply_q[$];
    int        pushed_count = 0;
    int        accepted_count = 0;
    int        mismatch_count = 0;
    bit        in_word_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_req_len = 0;
    int stall_req_id = 0;
    int stall_ack_id = 0;
    int stall_left = 0;

    function automatic reply_t predict_reply(input logic [1:0] op, input logic [7:0] rx);
        reply_t            r;
        bafc_pkg::status_t err;
        r = '{bafc_pkg::ST_PENDING, 4'd0, 1'b0, 8'd0, 6'd0};
        case (op)
            bafc_pkg::OP_ARM: begin
                rx_waiting = 1'b1;
                rx_in_frame = 1'b0;
                rx_position = '0;
                rx_elapsed = '0;
            end
            bafc_pkg::OP_TICK: begin
                if (rx_waiting) begin
                    if (rx_elapsed != bafc_pkg::TICK_MAX)
                        rx_elapsed = rx_elapsed + 1'b1;
                    if (rx_elapsed >= cfg_timeout) begin
                        r.status = bafc_pkg::ST_TIMEOUT;
                        rx_waiting = 1'b0;
                        rx_in_frame = 1'b0;
                        rx_position = '0;
                    end
                end
            end
            bafc_pkg::OP_BYTE: begin
                if (!rx_waiting) begin
                    // nothing armed, byte dropped
                end else if (!rx_in_frame) begin
                    if (rx == bafc_pkg::START_BYTE) begin
                        rx_in_frame = 1'b1;
                        rx_position = '0;
                    end
                end else if (rx_position < FRAME_MAX) begin
                    err = bafc_pkg::ST_PENDING;
                    if (rx_position == 0) begin
                        if (rx[0])
                            err = bafc_pkg::ST_NOT_ANSWER;
                        else if (!cfg_command[bafc_pkg::ASYNC_BIT] &&
                                 (cfg_command & bafc_pkg::CMD_MASK) !=
                                 (rx & bafc_pkg::CMD_MASK))
                            err = bafc_pkg::ST_WRONG_CMD;
                    end else if (rx_position == 1) begin
                        if (rx[bafc_pkg::ADDR_W-1:0] != cfg_address)
                            err = bafc_pkg::ST_WRONG_ADDR;
                    end
                    if (err != bafc_pkg::ST_PENDING) begin
                        r.status = err;
                        rx_waiting = 1'b0;
                        rx_in_frame = 1'b0;
                        rx_position = '0;
                    end else begin
                        r.stored = 1'b1;
                        r.body_byte = rx;
                        r.body_idx = rx_position[5:0];
                        rx_position = rx_position + 1'b1;
                        // a trailer byte ends the frame but keeps the position
                        if (rx_position > 2 && rx[7]) begin
                            if (rx[3:0] != 0) begin
                                r.status = bafc_pkg::ST_DEV_ERROR;
                                r.nibble = rx[3:0];
                            end else begin
                                r.status = bafc_pkg::ST_COMPLETE;
                            end
                            rx_waiting = 1'b0;
                            rx_in_frame = 1'b0;
                        end
                    end
                end else begin
                    r.status = bafc_pkg::ST_TOO_LONG;
                    rx_waiting = 1'b0;
                    rx_in_frame = 1'b0;
                    rx_position = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // sender: presents queued words, idles at random
    always @(negedge aclk) begin : feed
        bus_word_t w;
        if (aresetn && (!s_tvalid || in_word_taken)) begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= w.op;
                s_tdata <= w.rx;
            end else begin
                s_tvalid <= 1'b0;
                s_tdata <= 8'($urandom);
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(negedge aclk) begin
        if (stall_req_id != stall_ack_id) begin
            stall_ack_id = stall_req_id;
            stall_left = stall_req_len;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : observe
        reply_t want;
        if (!aresetn) begin
            in_word_taken = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("result word with no expectation: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $error("status expected %0d got %0d", want.status, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[6:3] !== want.nibble) begin
                        $error("device_error expected %0d got %0d", want.nibble, m_tdata[6:3]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.stored) begin
                        $error("byte_stored expected %0d got %0d", want.stored, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[14:7] !== want.body_byte) begin
                        $error("answer_byte expected %h got %h", want.body_byte, m_tdata[14:7]);
                        mismatch_count++;
                    end
                    if (m_tdata[20:15] !== want.body_idx) begin
                        $error("byte_index expected %0d got %0d", want.body_idx, m_tdata[20:15]);
                        mismatch_count++;
                    end
                end
            end
            in_word_taken = s_tvalid && s_tready;
            if (in_word_taken) begin
                reply_q.push_back(predict_reply(s_tuser, s_tdata));
                accepted_count++;
            end
        end
    end

    task automatic push_word(input logic [1:0] op, input logic [7:0] rx);
        word_q.push_back('{op, rx});
        pushed_count++;
    endtask

    task automatic write_reg(input bafc_pkg::cfg_reg_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            bafc_pkg::REG_COMMAND: cfg_command = val[7:0];
            bafc_pkg::REG_ADDRESS: cfg_address = val[5:0];
            bafc_pkg::REG_TIMEOUT: cfg_timeout = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] cmd, input logic [15:0] addr,
                                  input logic [15:0] tmo);
        write_reg(bafc_pkg::REG_COMMAND, cmd);
        write_reg(bafc_pkg::REG_ADDRESS, addr);
        write_reg(bafc_pkg::REG_TIMEOUT, tmo);
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (accepted_count != pushed_count || reply_q.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic maybe_tick();
        if ($urandom_range(7) == 0)
            push_word(bafc_pkg::OP_TICK, 8'($urandom));
    endtask

    // one reply attempt: arm, line noise, start byte, header, body, trailer
    task automatic queue_frame();
        frame_kind_t kind;
        logic [7:0]  b;
        int          body_len;
        if ($urandom_range(1))
            kind = FRAME_GOOD;
        else
            kind = frame_kind_t'($urandom_range(FRAME_SLOW));
        push_word(bafc_pkg::OP_ARM, 8'($urandom));
        repeat ($urandom_range(2)) begin
            b = 8'($urandom);
            if (b == bafc_pkg::START_BYTE)
                b = 8'h00;
            push_word(bafc_pkg::OP_BYTE, b);
            maybe_tick();
        end
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        maybe_tick();

        b = 8'($urandom);
        b[0] = 1'b0;
        if (!cfg_command[bafc_pkg::ASYNC_BIT])
            b[7:3] = cfg_command[7:3];
        if (kind == FRAME_NOT_ANSWER)
            b[0] = 1'b1;
        if (kind == FRAME_BAD_CMD)
            b[7:3] = b[7:3] ^ 5'($urandom_range(1, 31));
        push_word(bafc_pkg::OP_BYTE, b);
        if (kind == FRAME_NOT_ANSWER ||
            (kind == FRAME_BAD_CMD && !cfg_command[bafc_pkg::ASYNC_BIT]))
            return;
        maybe_tick();

        b = 8'($urandom);
        b[5:0] = cfg_address;
        if (kind == FRAME_BAD_ADDR)
            b[5:0] = b[5:0] ^ 6'($urandom_range(1, 63));
        push_word(bafc_pkg::OP_BYTE, b);
        if (kind == FRAME_BAD_ADDR)
            return;

        if (kind == FRAME_SLOW) begin
            repeat ($urandom_range(1, 40))
                push_word(bafc_pkg::OP_TICK, 8'($urandom));
        end
        if (kind == FRAME_OVERLONG)
            body_len = FRAME_MAX - 2 + int'($urandom_range(1, 3));
        else if ($urandom_range(9) == 0)
            body_len = int'($urandom_range(7, FRAME_MAX - 3));
        else
            body_len = int'($urandom_range(0, 6));
        repeat (body_len) begin
            b = 8'($urandom);
            b[7] = 1'b0;
            push_word(bafc_pkg::OP_BYTE, b);
            maybe_tick();
        end
        if (kind != FRAME_OVERLONG) begin
            b = 8'($urandom);
            b[7] = 1'b1;
            if ($urandom_range(1))
                b[3:0] = 4'h0;
            push_word(bafc_pkg::OP_BYTE, b);
        end
    endtask

    task automatic queue_random_traffic(input int n);
        int start;
        start = pushed_count;
        while (pushed_count - start < n) begin
            if ($urandom_range(99) < 75)
                queue_frame();
            else
                push_word(2'($urandom_range(OP_UNUSED)), 8'($urandom));
        end
    endtask

    initial begin
        #(4_000_000);
        $display("bus_answer_frame_checker_core verification failed");
        $finish;
    end

    initial begin : run
        int idle_send[4];
        int idle_recv[4];
        int seg;
        idle_send = '{0, 88, 0, 22};
        idle_recv = '{0, 0, 88, 22};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apply_settings(16'h00A8, 16'h002A, 16'd3);
        // words outside a wait, and the unused operation
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_TICK, 8'h00);
        push_word(OP_UNUSED, 8'hFF);
        // noise before the start byte, then a request echo (bit 0 set)
        push_word(bafc_pkg::OP_ARM, 8'h00);
        push_word(bafc_pkg::OP_BYTE, 8'h00);
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_BYTE, 8'hA9);
        // command mismatch
        push_word(bafc_pkg::OP_ARM, 8'h55);
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_BYTE, 8'h50);
        // address mismatch
        push_word(bafc_pkg::OP_ARM, 8'h00);
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_BYTE, 8'hAE);
        push_word(bafc_pkg::OP_BYTE, 8'h15);
        // clean reply with upper address bits set
        push_word(bafc_pkg::OP_ARM, 8'h00);
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_BYTE, 8'hA8);
        push_word(bafc_pkg::OP_BYTE, 8'hEA);
        push_word(bafc_pkg::OP_BYTE, 8'h7F);
        push_word(bafc_pkg::OP_BYTE, 8'h80);
        // device error in the first trailer position
        push_word(bafc_pkg::OP_ARM, 8'h00);
        push_word(bafc_pkg::OP_BYTE, bafc_pkg::START_BYTE);
        push_word(bafc_pkg::OP_BYTE, 8'hAC);
        push_word(bafc_pkg::OP_BYTE, 8'h2A);
        push_word(bafc_pkg::OP_BYTE, 8'h8F);
        // timeout
        push_word(bafc_pkg::OP_ARM, 8'h00);
        push_word(bafc_pkg::OP_TICK, 8'h00);
        push_word(bafc_pkg::OP_TICK, 8'h00);
        push_word(bafc_pkg::OP_TICK, 8'h00);
        wait_drained();

        for (seg = 0; seg < 8; seg++) begin
            send_idle_pct = idle_send[seg / 2];
            recv_stall_pct = idle_recv[seg / 2];
            case (seg)
                0: apply_settings(16'h0000, 16'h0000, 16'd0);
                1: apply_settings(16'h00FF, 16'h003F, 16'hFFFF);
                2: apply_settings(16'($urandom) & 16'hFFBF, 16'($urandom),
                                  16'($urandom_range(1, 60)));
                3: apply_settings(16'($urandom), 16'($urandom), 16'd1);
                5: apply_settings(16'($urandom), 16'($urandom), bafc_pkg::TIMEOUT_RESET);
                default: apply_settings(16'($urandom), 16'($urandom),
                                        16'($urandom_range(1, 60)));
            endcase
            if (seg == 2) begin
                // sender holds until everything has come back
                queue_random_traffic(55);
                wait_drained();
                queue_random_traffic(55);
            end else begin
                queue_random_traffic(110);
            end
            if (seg == 0) begin
                // long receiver hold-off so the core backs up into s_tready
                stall_req_len = 300;
                stall_req_id++;
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("bus_answer_frame_checker_core verification clean");
        else
            $display("bus_answer_frame_checker_core verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/bafc_pkg.sv
rtl/bafc_check.sv
rtl/bafc_skid.sv
rtl/bus_answer_frame_checker_core.sv
rtl/bafc_checker.sv
tb/sv/tb_bus_answer_frame_checker_core.sv
